@@ src/slt_pkg.sv @@
package slt_pkg;

  // Widths of the stream fields.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned ODATA_W = 16;

  // Defaults for the table size and the capacity register.
  localparam int unsigned DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes carried in the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

endpackage

@@ src/sorted_list_table_core.sv @@
// Sorted key table: keeps signed 32-bit keys in ascending order, duplicates allowed.
// Input stream: s_axis_tuser carries the command (insert, delete, search), s_axis_tdata
// the key. Every accepted word produces exactly one result word on the master side:
// tuser holds the success flag, tdata the hit position, the length after the command
// and the full flag. The config channel writes the capacity register (reset 16).
// Commands are handled one at a time by a sequencer around a key memory with one write
// port and a registered read port, and signed key comparisons. A search probes one
// midpoint at a time, reading it in S_SRCH and comparing it in S_CMP. An insert walks
// down from the top of the list, one entry per cycle, moving up the entries not smaller
// than the key. A delete searches for the key and then moves the entries above the hit
// down. With 16 entries the longest command is a delete of the bottom entry, and the
// next word is taken only once the sequencer is idle, since s_axis_tready is high only
// while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it there and the
// next command is accepted and worked on, waiting for that register only at its end.
// Reset empties the table and sets the capacity to 16; the memory itself is not
// cleared, since only entries below the length are ever used.
module sorted_list_table_core #(
  parameter int unsigned DEPTH = slt_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Config write channel: capacity.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [slt_pkg::CAP_W-1:0]   cfg_data_i,
  // Command stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [slt_pkg::KEY_W-1:0]   s_axis_tdata,   // [31:0] key
  input  logic [slt_pkg::CMD_W-1:0]   s_axis_tuser,   // [1:0] cmd
  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [slt_pkg::ODATA_W-1:0] m_axis_tdata,   // [3:0] position, [8:4] length,
                                                      // [9] full_res, [15:10] zero
  output logic                        m_axis_tuser    // [0] ok
);
  import slt_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS0,
    S_SRCH,
    S_CMP,
    S_DEL,
    S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [CAP_W-1:0]          cap_q, cap_d;
  logic [CW-1:0]             count_q, count_d;
  logic signed [KEY_W-1:0]   key_q, key_d;
  logic [CMD_W-1:0]          cmd_q, cmd_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             lo_q, lo_d;
  logic [CW-1:0]             hx_q, hx_d;
  logic [IW-1:0]             mid_q, mid_d;
  logic                      ok_q, ok_d;
  logic [IW-1:0]             pos_q, pos_d;
  logic                      m_valid_q, m_valid_d;
  logic [ODATA_W-1:0]        m_data_q, m_data_d;
  logic                      m_ok_q, m_ok_d;

  // Key memory: one write and one registered read per cycle.
  logic [KEY_W-1:0]          mem [DEPTH];
  logic                      we;
  logic [IW-1:0]             waddr;
  logic [KEY_W-1:0]          wdata;
  logic [IW-1:0]             raddr;
  logic signed [KEY_W-1:0]   rdata_q;

  logic                      in_hs;
  logic                      room;
  logic                      full;
  logic [CW:0]               mid_sum;
  logic [CW:0]               idx_p1;
  logic [CW:0]               idx_p2;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Room for an insert: below the capacity and below the table size.
  assign room = (WW'(count_q) < WW'(cap_q)) && (count_q != CW'(DEPTH));
  assign full = !room;

  // Midpoint of the half-open window [lo, hx).
  assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - (CW+1)'(1);
  assign idx_p1  = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2  = {1'b0, idx_q} + (CW+1)'(2);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cap_d     = cap_q;
    count_d   = count_q;
    key_d     = key_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    lo_d      = lo_q;
    hx_d      = hx_q;
    mid_d     = mid_q;
    ok_d      = ok_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_ok_d    = m_ok_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = key_q;
    raddr     = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          key_d = s_axis_tdata;
          cmd_d = s_axis_tuser;
          ok_d  = 1'b0;
          pos_d = '0;
          lo_d  = '0;
          hx_d  = count_q;
          case (s_axis_tuser) inside
            CMD_INSERT: begin
              if (!room) begin
                state_d = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_INS0;
              end else begin
                raddr   = IW'(count_q - CW'(1));
                idx_d   = count_q;
                state_d = S_INS;
              end
            end
            CMD_DELETE, CMD_SEARCH: begin
              state_d = S_SRCH;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Move entries not smaller than the key up by one, from the top down.
      S_INS: begin
        we    = 1'b1;
        waddr = IW'(idx_q);
        if (rdata_q >= key_q) begin
          wdata = rdata_q;
          if (idx_q == CW'(1)) begin
            state_d = S_INS0;
          end else begin
            raddr = IW'(idx_q - CW'(2));
            idx_d = idx_q - CW'(1);
          end
        end else begin
          wdata   = key_q;
          count_d = count_q + CW'(1);
          ok_d    = 1'b1;
          state_d = S_DONE;
        end
      end

      // The key goes to the bottom entry.
      S_INS0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = key_q;
        count_d = count_q + CW'(1);
        ok_d    = 1'b1;
        state_d = S_DONE;
      end

      // Issue the read of the next midpoint, or end on an empty window.
      S_SRCH: begin
        if (lo_q < hx_q) begin
          raddr   = IW'(mid_sum >> 1);
          mid_d   = IW'(mid_sum >> 1);
          state_d = S_CMP;
        end else begin
          state_d = S_DONE;
        end
      end

      // Compare the midpoint entry with the key.
      S_CMP: begin
        if (rdata_q == key_q) begin
          pos_d = mid_q;
          ok_d  = 1'b1;
          if (cmd_q == CMD_DELETE) begin
            if (CW'(mid_q) + CW'(1) < count_q) begin
              raddr   = IW'(CW'(mid_q) + CW'(1));
              idx_d   = CW'(mid_q);
              state_d = S_DEL;
            end else begin
              count_d = count_q - CW'(1);
              state_d = S_DONE;
            end
          end else begin
            state_d = S_DONE;
          end
        end else if (key_q > rdata_q) begin
          lo_d    = CW'(mid_q) + CW'(1);
          state_d = S_SRCH;
        end else begin
          hx_d    = CW'(mid_q);
          state_d = S_SRCH;
        end
      end

      // Move the entries above the hit down by one.
      S_DEL: begin
        we    = 1'b1;
        waddr = IW'(idx_q);
        wdata = rdata_q;
        if (idx_p2 < {1'b0, count_q}) begin
          raddr = IW'(idx_p2);
          idx_d = CW'(idx_p1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      // Load the result word once the output register is free.
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_ok_d    = ok_q;
          m_data_d  = '0;
          m_data_d[POS_W-1:0]           = POS_W'(pos_q);
          m_data_d[POS_W +: LEN_W]      = LEN_W'(count_q);
          m_data_d[POS_W + LEN_W]       = full;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cap_q     <= CAP_RESET;
      count_q   <= '0;
      key_q     <= '0;
      cmd_q     <= '0;
      idx_q     <= '0;
      lo_q      <= '0;
      hx_q      <= '0;
      mid_q     <= '0;
      ok_q      <= 1'b0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_ok_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_q     <= cap_d;
      count_q   <= count_d;
      key_q     <= key_d;
      cmd_q     <= cmd_d;
      idx_q     <= idx_d;
      lo_q      <= lo_d;
      hx_q      <= hx_d;
      mid_q     <= mid_d;
      ok_q      <= ok_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_ok_q    <= m_ok_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_ok_q;

endmodule

@@ src/slt_checker.sv @@
module slt_checker #(
  parameter int unsigned DEPTH = slt_pkg::DEPTH_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [slt_pkg::CAP_W-1:0]   cfg_data_i,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [slt_pkg::KEY_W-1:0]   s_axis_tdata,
  input logic [slt_pkg::CMD_W-1:0]   s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [slt_pkg::ODATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tuser
);
  import slt_pkg::*;

  // A result word waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // The block works on one command at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while another is in work");

  // A miss or a failed insert reports position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[POS_W-1:0] == '0)
    else $error("nonzero position without success");

  // The reported length never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (DEPTH < 32) |->
      32'(m_axis_tdata[POS_W +: LEN_W]) <= 32'(DEPTH))
    else $error("length above table size");

endmodule

bind sorted_list_table_core slt_checker #(.DEPTH(DEPTH)) u_slt_checker (.*);
